FILE: hw/rtl/rssi_report_packet_framer_assert.svh
// Assertion macros for the checker file of the report framer.
`ifndef RSSI_REPORT_PACKET_FRAMER_ASSERT_SVH
`define RSSI_REPORT_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define RRPF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define RRPF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rrpf_pkg.sv
// Types, constants and the CRC step function of the link report framer.
`default_nettype none

package rrpf_pkg;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned PosW     = 4;

  localparam logic [15:0]     CRC_INIT      = 16'hFFFF;
  localparam logic [7:0]      CRC_TRAILER   = 8'd123;
  localparam logic [7:0]      REPORT_MSG_ID = 8'd1;
  localparam logic [7:0]      PAYLOAD_LEN   = 8'd5;
  localparam logic [15:0]     PKT_BYTES     = 16'd13;
  localparam logic [PosW-1:0] CRC_LAST      = 4'd9;
  localparam logic [PosW-1:0] COBS_FIRST    = 4'd11;
  localparam logic [PosW-1:0] COBS_END      = 4'd12;
  localparam logic [PosW-1:0] EMIT_LAST     = 4'd12;

  typedef enum logic {
    REG_OWN_NODE,
    REG_NODE_TOTAL
  } rrpf_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REFUSE,
    ST_ADVANCE,
    ST_READ,
    ST_CRC,
    ST_COBS,
    ST_EMIT
  } rrpf_state_e;

  typedef struct packed {
    logic        command;
    logic [3:0]  stat_node;
    logic [7:0]  local_rssi;
    logic [7:0]  remote_rssi;
    logic [7:0]  local_noise;
    logic [7:0]  remote_noise;
    logic [15:0] tx_space;
  } rrpf_cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       sent;
  } rrpf_res_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [31:0] data;
  } rrpf_stat_wr_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } rrpf_stat_rd_t;

  // One byte of CRC-16/MCRF4XX (reflected 0x1021), in the folded form.
  function automatic logic [15:0] crc_mcrf4xx_byte(input logic [15:0] sum,
                                                   input logic [7:0]  b);
    logic [7:0]  t;
    logic [15:0] w;
    t = b ^ sum[7:0];
    t = t ^ {t[3:0], 4'b0000};
    w = {8'h00, t};
    crc_mcrf4xx_byte = {8'h00, sum[15:8]} ^ {w[7:0], 8'h00} ^ {w[12:0], 3'b000}
                       ^ {4'h0, w[15:4]};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rrpf_stat_table.sv
// Per-node link statistics memory with reset-cleared valid bits.
`default_nettype none

module rrpf_stat_table #(
  parameter int unsigned Depth = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rrpf_pkg::rrpf_stat_wr_t wr_i,
  input  rrpf_pkg::rrpf_stat_rd_t rd_i,
  output logic [31:0]            rd_data_o
);
  import rrpf_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [31:0]      mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [31:0]      rd_word_q;
  logic             rd_hit_q;
  logic             wr_in_range;
  logic             rd_in_range;

  assign wr_in_range = ({24'd0, wr_i.addr} < 32'(Depth));
  assign rd_in_range = ({24'd0, rd_i.addr} < 32'(Depth));

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range) begin
      mem[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_word_q <= mem[rd_i.addr[AddrW-1:0]];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (wr_i.en && wr_in_range) begin
        valid_q[wr_i.addr[AddrW-1:0]] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_hit_q <= rd_in_range && valid_q[rd_i.addr[AddrW-1:0]];
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_word_q : 32'd0;

endmodule

`default_nettype wire

FILE: hw/rtl/rssi_report_packet_framer.sv
// Link statistics table and COBS/CRC-16 report packet framer, top level.
`default_nettype none

// A write command (command = 0) stores one node's statistics in the cycle it
// is taken and leaves busy low. A report command with tx_space below 13
// raises busy for one cycle and gives a single refusal result in the cycle
// after the request. A report that fits keeps busy high while it advances
// the round-robin index, reads the statistics memory, runs the byte-serial
// CRC unit, runs the backward COBS pass over the packet buffer, and then
// emits the packet one byte per cycle. The result strobe is high for each
// byte and cannot be held off. Configuration is a word-mapped APB port:
// own_node_id at 0x0, node_total at 0x4.
module rssi_report_packet_framer #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  rrpf_pkg::rrpf_cmd_t               cmd_i,
  output logic                              res_strobe_o,
  output rrpf_pkg::rrpf_res_t               result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rrpf_pkg::ApbAddrW-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import rrpf_pkg::*;

  rrpf_state_e       state_q, state_d;
  logic [PosW-1:0]   cnt_q;
  logic [7:0]        own_q;
  logic [4:0]        total_q;
  logic [7:0]        rr_q;
  logic [7:0]        seq_q;
  logic [15:0]       crc_q;
  logic [PosW-1:0]   nz_q;
  logic [7:0]        buf_q [13];

  logic              accept;
  logic              cfg_wr;
  rrpf_reg_e         reg_sel;
  logic [7:0]        rr_inc1;
  logic [7:0]        rr_inc2;
  logic [7:0]        rr_next;
  logic [7:0]        crc_in;
  logic [7:0]        cobs_in;
  logic [31:0]       entry;
  rrpf_stat_wr_t     stat_wr;
  rrpf_stat_rd_t     stat_rd;

  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = rrpf_reg_e'(paddr[2]);

  always_comb begin
    case (reg_sel)
      REG_OWN_NODE:   prdata = {24'd0, own_q};
      REG_NODE_TOTAL: prdata = {27'd0, total_q};
      default:        prdata = 32'd0;
    endcase
  end

  // Statistics memory: writes come straight from a write request.
  assign stat_wr.en   = accept && !cmd_i.command;
  assign stat_wr.addr = {4'd0, cmd_i.stat_node};
  assign stat_wr.data = {cmd_i.remote_noise, cmd_i.local_noise,
                         cmd_i.remote_rssi, cmd_i.local_rssi};
  assign stat_rd.en   = (state_q == ST_READ);
  assign stat_rd.addr = rr_q;

  rrpf_stat_table #(
    .Depth(MAX_NODES)
  ) u_stat_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (stat_wr),
    .rd_i     (stat_rd),
    .rd_data_o(entry)
  );

  // Round robin: skip our own node once, wrap at the node count.
  assign rr_inc1 = rr_q + 8'd1;
  assign rr_inc2 = (rr_inc1 == own_q) ? rr_inc1 + 8'd1 : rr_inc1;
  assign rr_next = (rr_inc2 >= {3'd0, total_q}) ? 8'd0 : rr_inc2;

  always_comb begin
    case (cnt_q)
      4'd0:    crc_in = PAYLOAD_LEN;
      4'd1:    crc_in = seq_q;
      4'd2:    crc_in = own_q;
      4'd3:    crc_in = REPORT_MSG_ID;
      4'd4:    crc_in = rr_q;
      4'd5:    crc_in = entry[7:0];
      4'd6:    crc_in = entry[15:8];
      4'd7:    crc_in = entry[23:16];
      4'd8:    crc_in = entry[31:24];
      default: crc_in = CRC_TRAILER;
    endcase
  end

  // The CRC bytes land at the tail of the packet during the COBS pass.
  always_comb begin
    if (cnt_q == COBS_FIRST) begin
      cobs_in = crc_q[15:8];
    end else if (cnt_q == COBS_FIRST - 4'd1) begin
      cobs_in = crc_q[7:0];
    end else begin
      cobs_in = buf_q[cnt_q];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i.command) begin
          state_d = (cmd_i.tx_space < PKT_BYTES) ? ST_REFUSE : ST_ADVANCE;
        end
      end
      ST_REFUSE:  state_d = ST_IDLE;
      ST_ADVANCE: state_d = ST_READ;
      ST_READ:    state_d = ST_CRC;
      ST_CRC: begin
        if (cnt_q == CRC_LAST) begin
          state_d = ST_COBS;
        end
      end
      ST_COBS: begin
        if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cnt_q == EMIT_LAST) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_q != ST_IDLE);
    res_strobe_o = 1'b0;
    result_o     = '0;
    case (state_q)
      ST_REFUSE: begin
        res_strobe_o  = 1'b1;
        result_o.last = 1'b1;
      end
      ST_EMIT: begin
        res_strobe_o      = 1'b1;
        result_o.sent     = 1'b1;
        result_o.last     = (cnt_q == EMIT_LAST);
        result_o.out_byte = (cnt_q == EMIT_LAST) ? 8'd0 : buf_q[cnt_q];
      end
      default: begin
        res_strobe_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      own_q   <= 8'd0;
      total_q <= 5'd1;
      rr_q    <= 8'd0;
      seq_q   <= 8'd0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (reg_sel)
          REG_OWN_NODE:   own_q   <= pwdata[7:0];
          REG_NODE_TOTAL: total_q <= pwdata[4:0];
          default:        own_q   <= own_q;
        endcase
      end
      case (state_q)
        ST_ADVANCE: begin
          rr_q  <= rr_next;
          cnt_q <= '0;
        end
        ST_CRC: begin
          if (cnt_q == CRC_LAST) begin
            cnt_q <= COBS_FIRST;
            seq_q <= seq_q + 8'd1;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_COBS: begin
          // The emit pass starts from byte zero.
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        ST_EMIT: begin
          cnt_q <= cnt_q + 4'd1;
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_READ: begin
        crc_q <= CRC_INIT;
      end
      ST_CRC: begin
        crc_q <= crc_mcrf4xx_byte(crc_q, crc_in);
        if (cnt_q != CRC_LAST) begin
          buf_q[cnt_q + 4'd1] <= crc_in;
        end
        nz_q <= COBS_END;
      end
      ST_COBS: begin
        // Walking backward, each zero becomes the distance to the next zero.
        if (cnt_q == '0) begin
          buf_q[0] <= {4'd0, nz_q};
        end else if (cobs_in == 8'd0) begin
          buf_q[cnt_q] <= {4'd0, nz_q - cnt_q};
          nz_q         <= cnt_q;
        end else begin
          buf_q[cnt_q] <= cobs_in;
        end
      end
      default: begin
        nz_q <= nz_q;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rrpf_checker.sv
// Port-level checks of the report framer, bound to its top level.
`default_nettype none
`include "rssi_report_packet_framer_assert.svh"

module rrpf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input rrpf_pkg::rrpf_cmd_t cmd_i,
  input logic                res_strobe_o,
  input rrpf_pkg::rrpf_res_t result_o
);
  import rrpf_pkg::*;

  // A report request always raises busy after it is taken.
  `RRPF_ASSERT_NXT(a_report_busy, start && !busy && cmd_i.command, busy, "report not busy")
  // A statistics write completes without ever raising busy.
  `RRPF_ASSERT_NXT(a_write_quick, start && !busy && !cmd_i.command, !busy, "write took busy")
  // Packet bytes come out back to back until the last one.
  `RRPF_ASSERT_NXT(a_bytes_gapless, res_strobe_o && !result_o.last, res_strobe_o, "byte gap")
  // A refusal is a single zero byte marked last.
  `RRPF_ASSERT_IMP(a_refusal_form, res_strobe_o && !result_o.sent,
                   result_o.last && (result_o.out_byte == 8'd0), "bad refusal")
  // Results only appear while a request is in progress.
  `RRPF_ASSERT_IMP(a_result_busy, res_strobe_o, busy, "result while idle")

endmodule

bind rssi_report_packet_framer rrpf_checker u_rrpf_checker (.*);

`default_nettype wire
